FILE: hdl/nnpt_pkg.sv
package nnpt_pkg;

    localparam int unsigned MaxTracksDef = 16;
    localparam int unsigned MaxDetectionsDef = 16;

    localparam logic [22:0] MatchDistanceRst = 23'd256;
    localparam logic [8:0]  SmoothingGainRst = 9'd128;
    localparam logic [7:0]  StaleLimitRst    = 8'd10;

    localparam logic [1:0] RegMatchDistance = 2'd0;
    localparam logic [1:0] RegSmoothingGain = 2'd1;
    localparam logic [1:0] RegStaleLimit    = 2'd2;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic               has_point;
        logic               frame_end;
    } point_item_t;

    typedef struct packed {
        logic [15:0]        track_id;
        logic signed [23:0] track_x;
        logic signed [23:0] track_y;
        logic               seen_now;
        logic               no_tracks;
        logic               overflowed;
        logic               last_of_frame;
    } track_item_t;

    // controller to datapath
    typedef struct packed {
        logic store_det;
        logic clr_frame;
        logic det_rd;
        logic best_clr;
        logic dist_acc;
        logic upd_track;
        logic new_track;
        logic cmp_rd;
        logic cmp_wr;
        logic emit_trk;
        logic emit_none;
    } nnpt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic det_taken;
        logic found;
        logic stale;
        logic det_full;
        logic trk_full;
    } nnpt_sts_t;

endpackage

FILE: hdl/nnpt_ram.sv
module nnpt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/nnpt_datapath.sv
module nnpt_datapath import nnpt_pkg::*; #(
    parameter int unsigned MAX_TRACKS = MaxTracksDef,
    parameter int unsigned MAX_DETECTIONS = MaxDetectionsDef
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nnpt_cmd_t                         cmd,
    output nnpt_sts_t                         sts,
    input  logic [$clog2(MAX_TRACKS)-1:0]     trk_idx,
    input  logic [$clog2(MAX_TRACKS)-1:0]     wr_idx,
    input  logic [$clog2(MAX_DETECTIONS)-1:0] det_idx,
    input  point_item_t                       item,
    input  logic [22:0]                       match_distance,
    input  logic [8:0]                        smoothing_gain,
    input  logic [7:0]                        stale_limit,
    output logic [$clog2(MAX_TRACKS):0]       track_count,
    output logic [$clog2(MAX_DETECTIONS):0]   det_count,
    output track_item_t                       result,
    output logic                              strobe
);

    localparam int unsigned TW = $clog2(MAX_TRACKS);
    localparam int unsigned DW = $clog2(MAX_DETECTIONS);
    localparam logic [TW:0] TrkMax = (TW+1)'(MAX_TRACKS);
    localparam logic [DW:0] DetMax = (DW+1)'(MAX_DETECTIONS);

    logic [DW:0]              det_cnt_reg;
    logic [MAX_DETECTIONS-1:0] taken_reg;
    logic [TW:0]              trk_cnt_reg;
    logic [15:0]              next_id_reg;
    logic                     ovf_reg;
    logic [47:0]              best_d_reg;
    logic [DW-1:0]            best_i_reg;
    logic                     found_reg;
    logic [47:0]              limit2_reg;
    logic [DW-1:0]            det_cur_reg;
    track_item_t              res_reg;
    logic                     strobe_reg;

    logic [47:0] det_rdata;
    logic [47:0] pos_rdata;
    logic [15:0] id_rdata;
    logic [7:0]  uns_rdata;

    logic [TW-1:0] pos_waddr;
    logic [47:0]   pos_wdata;
    logic          pos_we;
    logic [15:0]   id_wdata;
    logic          id_we;
    logic [7:0]    uns_wdata;
    logic          uns_we;
    logic [DW-1:0] det_raddr;
    logic          det_full;
    logic          trk_full;
    logic          closer;

    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [24:0]        adx;
    logic [24:0]        ady;
    logic [49:0]        sqx;
    logic [49:0]        sqy;
    logic [50:0]        d2;
    logic [8:0]         g;
    logic [24:0]        ax, bx, ay, by;
    logic [34:0]        sx, sy;
    logic signed [23:0] nx, ny;
    logic [7:0]         uns_inc;

    assign det_full  = (det_cnt_reg == DetMax);
    assign trk_full  = (trk_cnt_reg == TrkMax);
    // best detection is fetched for the update cycle
    assign det_raddr = cmd.det_rd ? best_i_reg : det_idx;

    nnpt_ram #(.WIDTH(48), .DEPTH(MAX_DETECTIONS)) u_det (
        .clk(clk), .we(cmd.store_det && !det_full),
        .waddr(det_cnt_reg[DW-1:0]), .wdata({item.point_x, item.point_y}),
        .raddr(det_raddr), .rdata(det_rdata)
    );
    nnpt_ram #(.WIDTH(48), .DEPTH(MAX_TRACKS)) u_pos (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(trk_idx), .rdata(pos_rdata)
    );
    nnpt_ram #(.WIDTH(16), .DEPTH(MAX_TRACKS)) u_id (
        .clk(clk), .we(id_we), .waddr(pos_waddr), .wdata(id_wdata),
        .raddr(trk_idx), .rdata(id_rdata)
    );
    nnpt_ram #(.WIDTH(8), .DEPTH(MAX_TRACKS)) u_uns (
        .clk(clk), .we(uns_we), .waddr(pos_waddr), .wdata(uns_wdata),
        .raddr(trk_idx), .rdata(uns_rdata)
    );

    // squared distance, one detection per cycle
    always_comb
    begin
        dx  = 25'(signed'(det_rdata[47:24])) - 25'(signed'(pos_rdata[47:24]));
        dy  = 25'(signed'(det_rdata[23:0])) - 25'(signed'(pos_rdata[23:0]));
        adx = dx[24] ? 25'(-dx) : 25'(dx);
        ady = dy[24] ? 25'(-dy) : 25'(dy);
        sqx = adx * adx;
        sqy = ady * ady;
        d2  = {1'b0, sqx} + {1'b0, sqy};
    end

    // detection on the read port is det_cur_reg
    assign closer = cmd.dist_acc && !taken_reg[det_cur_reg] &&
                    (51'(d2) < 51'(found_reg ? best_d_reg : limit2_reg));

    // smoothing on offset-binary values
    always_comb
    begin
        g  = (smoothing_gain > 9'd256) ? 9'd256 : smoothing_gain;
        ax = {~pos_rdata[47], pos_rdata[46:24]} & 25'hFFFFFF;
        bx = {~det_rdata[47], det_rdata[46:24]} & 25'hFFFFFF;
        ay = {~pos_rdata[23], pos_rdata[22:0]} & 25'hFFFFFF;
        by = {~det_rdata[23], det_rdata[22:0]} & 25'hFFFFFF;
        sx = (35'(ax) * 35'(9'd256 - g) + 35'(bx) * 35'(g) + 35'd128) >> 8;
        sy = (35'(ay) * 35'(9'd256 - g) + 35'(by) * 35'(g) + 35'd128) >> 8;
        nx = {~sx[23], sx[22:0]};
        ny = {~sy[23], sy[22:0]};
        uns_inc = (uns_rdata == 8'd255) ? uns_rdata : uns_rdata + 8'd1;
    end

    always_comb
    begin
        pos_we    = 1'b0;
        id_we     = 1'b0;
        uns_we    = 1'b0;
        pos_waddr = trk_idx;
        pos_wdata = {nx, ny};
        id_wdata  = id_rdata;
        uns_wdata = 8'd0;
        if (cmd.upd_track)
        begin
            pos_we    = found_reg;
            uns_we    = 1'b1;
            uns_wdata = found_reg ? 8'd0 : uns_inc;
        end
        else if (cmd.new_track)
        begin
            pos_waddr = trk_cnt_reg[TW-1:0];
            pos_we    = !trk_full;
            id_we     = !trk_full;
            uns_we    = !trk_full;
            pos_wdata = det_rdata;
            id_wdata  = next_id_reg;
        end
        else if (cmd.cmp_wr)
        begin
            pos_waddr = wr_idx;
            pos_we    = 1'b1;
            id_we     = 1'b1;
            uns_we    = 1'b1;
            pos_wdata = pos_rdata;
            uns_wdata = uns_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_cnt_reg <= '0;
            taken_reg   <= '0;
            trk_cnt_reg <= '0;
            next_id_reg <= '0;
            ovf_reg     <= 1'b0;
            found_reg   <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_trk || cmd.emit_none;
            if (cmd.store_det)
            begin
                if (det_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    det_cnt_reg <= det_cnt_reg + 1'b1;
                end
            end
            if (cmd.best_clr)
            begin
                found_reg <= 1'b0;
            end
            if (closer)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.upd_track && found_reg)
            begin
                taken_reg[best_i_reg] <= 1'b1;
            end
            if (cmd.new_track)
            begin
                if (trk_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    trk_cnt_reg <= trk_cnt_reg + 1'b1;
                    next_id_reg <= next_id_reg + 16'd1;
                end
            end
            if (cmd.cmp_rd)
            begin
                trk_cnt_reg <= {1'b0, wr_idx} + (cmd.cmp_wr ? 1'b1 : 1'b0);
            end
            if (cmd.clr_frame)
            begin
                det_cnt_reg <= '0;
                taken_reg   <= '0;
                ovf_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit2_reg  <= 48'(match_distance) * 48'(match_distance);
        det_cur_reg <= det_raddr;
        if (closer)
        begin
            best_d_reg <= d2[47:0];
            best_i_reg <= det_cur_reg;
        end
        if (cmd.emit_trk)
        begin
            res_reg.track_id      <= id_rdata;
            res_reg.track_x       <= pos_rdata[47:24];
            res_reg.track_y       <= pos_rdata[23:0];
            res_reg.seen_now      <= (uns_rdata == 8'd0);
            res_reg.no_tracks     <= 1'b0;
            res_reg.overflowed    <= ovf_reg;
            res_reg.last_of_frame <= ({1'b0, trk_idx} + 1'b1 == trk_cnt_reg);
        end
        else if (cmd.emit_none)
        begin
            res_reg <= '{track_id: '0, track_x: '0, track_y: '0, seen_now: 1'b0,
                         no_tracks: 1'b1, overflowed: ovf_reg, last_of_frame: 1'b1};
        end
    end

    assign sts.det_taken = taken_reg[det_idx];
    assign sts.found     = found_reg;
    assign sts.stale     = uns_rdata > stale_limit;
    assign sts.det_full  = det_full;
    assign sts.trk_full  = trk_full;
    assign track_count   = trk_cnt_reg;
    assign det_count     = det_cnt_reg;
    assign result        = res_reg;
    assign strobe        = strobe_reg;

endmodule

FILE: hdl/nnpt_ctrl.sv
module nnpt_ctrl import nnpt_pkg::*; #(
    parameter int unsigned MAX_TRACKS = MaxTracksDef,
    parameter int unsigned MAX_DETECTIONS = MaxDetectionsDef
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  point_item_t                       item,
    input  nnpt_sts_t                         sts,
    input  logic [$clog2(MAX_TRACKS):0]       track_count,
    input  logic [$clog2(MAX_DETECTIONS):0]   det_count,
    output nnpt_cmd_t                         cmd,
    output logic [$clog2(MAX_TRACKS)-1:0]     trk_idx,
    output logic [$clog2(MAX_TRACKS)-1:0]     wr_idx,
    output logic [$clog2(MAX_DETECTIONS)-1:0] det_idx,
    output logic                              busy
);

    localparam int unsigned TW = $clog2(MAX_TRACKS);
    localparam int unsigned DW = $clog2(MAX_DETECTIONS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRD   = 4'd1;
    localparam logic [3:0] S_DIST  = 4'd2;
    localparam logic [3:0] S_URD   = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_NRD   = 4'd5;
    localparam logic [3:0] S_NEW   = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_CWR   = 4'd8;
    localparam logic [3:0] S_ERD   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;
    localparam logic [3:0] S_START = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [TW:0] t_reg, t_next;
    logic [TW:0] w_reg, w_next;
    logic [DW:0] d_reg, d_next;
    logic [TW:0] tc;

    assign tc = track_count;

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        w_next     = w_reg;
        d_next     = d_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.store_det = item.has_point;
                    if (item.frame_end)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                t_next = '0;
                state_next = (tc == '0) ? S_NRD : S_TRD;
                d_next = '0;
            end
            S_TRD:
            begin
                cmd.best_clr = 1'b1;
                d_next = '0;
                state_next = (det_count == '0) ? S_URD : S_DIST;
            end
            S_DIST:
            begin
                cmd.dist_acc = 1'b1;
                d_next = d_reg + 1'b1;
                if (d_reg + 1'b1 == det_count)
                begin
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                cmd.det_rd = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd_track = 1'b1;
                t_next = t_reg + 1'b1;
                d_next = '0;
                if (t_reg + 1'b1 == tc)
                begin
                    state_next = S_NRD;
                end
                else
                begin
                    state_next = S_TRD;
                end
            end
            S_NRD:
            begin
                if (d_reg == det_count)
                begin
                    t_next = '0;
                    w_next = '0;
                    state_next = (tc == '0) ? S_ERD : S_CRD;
                end
                else if (sts.det_taken)
                begin
                    d_next = d_reg + 1'b1;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end
            S_NEW:
            begin
                cmd.new_track = 1'b1;
                d_next = d_reg + 1'b1;
                state_next = S_NRD;
            end
            S_CRD:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                t_next = t_reg + 1'b1;
                if (!sts.stale)
                begin
                    cmd.cmp_wr = 1'b1;
                    w_next = w_reg + 1'b1;
                end
                if (t_reg + 1'b1 == tc)
                begin
                    cmd.cmp_rd = 1'b1;
                    t_next = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_ERD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (tc == '0)
                begin
                    cmd.emit_none = 1'b1;
                    cmd.clr_frame = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit_trk = 1'b1;
                    t_next = t_reg + 1'b1;
                    if (t_reg + 1'b1 == tc)
                    begin
                        cmd.clr_frame = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            t_reg     <= '0;
            w_reg     <= '0;
            d_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            w_reg     <= w_next;
            d_reg     <= d_next;
        end
    end

    // S_DIST reads detection d+1 ahead of use: address from next value
    assign det_idx = DW'((state_reg == S_DIST || state_reg == S_TRD) ? d_next :
                         (state_reg == S_URD || state_reg == S_UPD) ? d_reg : d_reg);
    assign trk_idx = t_reg[TW-1:0];
    assign wr_idx  = w_reg[TW-1:0];
    assign busy    = (state_reg != S_IDLE);

`ifndef NO_ASSERTIONS
    a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(cmd.emit_trk || cmd.upd_track || cmd.new_track))
        else $error("datapath command while idle");
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_trk |-> (t_reg < tc))
        else $error("emit beyond table");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_frame |=> (state_reg == S_IDLE))
        else $error("frame end not followed by idle");
`endif

endmodule

FILE: hdl/nearest_neighbour_point_tracker_unit.sv
// Greedy nearest-neighbour tracker. An item without frame_end is accepted
// while idle. The item with frame_end then holds busy while the update runs:
// a set-up state, then for each stored track a distance search over the
// detections (one detection per cycle through a shared squared-distance unit),
// a fetch of the best detection and the track update, then a pass over the
// detections that opens a new track for each one left unmatched, a read and a
// write state per track for compaction, and a read and an emit state per
// emitted result (also for the empty-table result). Results leave on strobe
// and cannot be held off.
module nearest_neighbour_point_tracker_unit import nnpt_pkg::*; #(
    parameter int unsigned MAX_TRACKS = MaxTracksDef,
    parameter int unsigned MAX_DETECTIONS = MaxDetectionsDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  point_item_t point,
    output logic        strobe,
    output track_item_t track,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned TW = $clog2(MAX_TRACKS);
    localparam int unsigned DW = $clog2(MAX_DETECTIONS);

    logic [22:0] match_distance_reg;
    logic [8:0]  smoothing_gain_reg;
    logic [7:0]  stale_limit_reg;

    nnpt_cmd_t     cmd;
    nnpt_sts_t     sts;
    logic [TW-1:0] trk_idx, wr_idx;
    logic [DW-1:0] det_idx;
    logic [TW:0]   track_count;
    logic [DW:0]   det_count;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_distance_reg <= MatchDistanceRst;
            smoothing_gain_reg <= SmoothingGainRst;
            stale_limit_reg    <= StaleLimitRst;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                RegMatchDistance: match_distance_reg <= pwdata[22:0];
                RegSmoothingGain: smoothing_gain_reg <= pwdata[8:0];
                RegStaleLimit:    stale_limit_reg    <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            RegMatchDistance: prdata = {9'd0, match_distance_reg};
            RegSmoothingGain: prdata = {23'd0, smoothing_gain_reg};
            RegStaleLimit:    prdata = {24'd0, stale_limit_reg};
            default:          prdata = '0;
        endcase
    end

    nnpt_ctrl #(.MAX_TRACKS(MAX_TRACKS), .MAX_DETECTIONS(MAX_DETECTIONS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start && !busy), .item(point), .sts(sts),
        .track_count(track_count), .det_count(det_count), .cmd(cmd),
        .trk_idx(trk_idx), .wr_idx(wr_idx), .det_idx(det_idx), .busy(busy)
    );

    nnpt_datapath #(.MAX_TRACKS(MAX_TRACKS), .MAX_DETECTIONS(MAX_DETECTIONS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .trk_idx(trk_idx),
        .wr_idx(wr_idx), .det_idx(det_idx), .item(point),
        .match_distance(match_distance_reg), .smoothing_gain(smoothing_gain_reg),
        .stale_limit(stale_limit_reg), .track_count(track_count),
        .det_count(det_count), .result(track), .strobe(strobe)
    );

endmodule

FILE: sim/nearest_neighbour_point_tracker_unit_test.sv
module nearest_neighbour_point_tracker_unit_test;
    import nnpt_pkg::*;

    localparam int unsigned NTRK = MaxTracksDef;
    localparam int unsigned NDET = MaxDetectionsDef;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    point_item_t point;
    logic        strobe;
    track_item_t track;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nearest_neighbour_point_tracker_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .point   (point),
        .strobe  (strobe),
        .track   (track),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // tracker mirror
    logic [22:0]        cfg_match;
    logic [8:0]         cfg_gain;
    logic [7:0]         cfg_stale;
    logic signed [23:0] det_x [NDET];
    logic signed [23:0] det_y [NDET];
    bit                 det_used [NDET];
    int unsigned        det_n;
    logic signed [23:0] trk_x [NTRK];
    logic signed [23:0] trk_y [NTRK];
    logic [15:0]        trk_id [NTRK];
    logic [7:0]         trk_unseen [NTRK];
    int unsigned        trk_n;
    logic [15:0]        ident_next;
    bit                 ovf_pending;

    track_item_t expected_tracks [$];
    int unsigned errors;
    int unsigned frames_done;
    int unsigned results_seen;
    int unsigned cycles;
    bit          took;
    bit          override_row;
    track_item_t override_item;

    function automatic longint sqd(logic signed [23:0] a, logic signed [23:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    function automatic logic signed [23:0] blend(logic signed [23:0] old,
                                                 logic signed [23:0] det, int g);
        longint a;
        longint b;
        longint r;
        a = longint'(old) + 8388608;
        b = longint'(det) + 8388608;
        r = (a * (256 - g) + b * g + 128) >>> 8;
        return 24'(r - 8388608);
    endfunction

    task automatic expect_item(track_item_t r);
        expected_tracks.insert(expected_tracks.size(), r);
    endtask

    task automatic absorb_point(point_item_t p);
        longint      lim2;
        longint      best;
        longint      d2;
        int          found;
        int          g;
        int unsigned kept;
        track_item_t r;
        if (p.has_point)
        begin
            if (det_n < NDET)
            begin
                det_x[det_n] = p.point_x;
                det_y[det_n] = p.point_y;
                det_used[det_n] = 1'b0;
                det_n++;
            end
            else
                ovf_pending = 1'b1;
        end
        if (!p.frame_end)
            return;
        frames_done++;
        lim2 = longint'(cfg_match) * longint'(cfg_match);
        g = (cfg_gain > 256) ? 256 : int'(cfg_gain);
        for (int t = 0; t < trk_n; t++)
        begin
            best = lim2;
            found = -1;
            for (int i = 0; i < det_n; i++)
            begin
                if (det_used[i])
                    continue;
                d2 = sqd(det_x[i], trk_x[t]) + sqd(det_y[i], trk_y[t]);
                if (d2 < best)
                begin
                    best = d2;
                    found = i;
                end
            end
            if (found >= 0)
            begin
                trk_x[t] = blend(trk_x[t], det_x[found], g);
                trk_y[t] = blend(trk_y[t], det_y[found], g);
                trk_unseen[t] = 8'd0;
                det_used[found] = 1'b1;
            end
            else if (trk_unseen[t] != 8'd255)
                trk_unseen[t]++;
        end
        for (int i = 0; i < det_n; i++)
        begin
            if (det_used[i])
                continue;
            if (trk_n < NTRK)
            begin
                trk_x[trk_n] = det_x[i];
                trk_y[trk_n] = det_y[i];
                trk_id[trk_n] = ident_next;
                trk_unseen[trk_n] = 8'd0;
                trk_n++;
                ident_next++;
            end
            else
                ovf_pending = 1'b1;
        end
        kept = 0;
        for (int t = 0; t < trk_n; t++)
        begin
            if (trk_unseen[t] > cfg_stale)
                continue;
            trk_x[kept] = trk_x[t];
            trk_y[kept] = trk_y[t];
            trk_id[kept] = trk_id[t];
            trk_unseen[kept] = trk_unseen[t];
            kept++;
        end
        trk_n = kept;
        if (override_row)
            expect_item(override_item);
        else if (trk_n == 0)
        begin
            r = '0;
            r.no_tracks = 1'b1;
            r.overflowed = ovf_pending;
            r.last_of_frame = 1'b1;
            expect_item(r);
        end
        else
            for (int t = 0; t < trk_n; t++)
            begin
                r.track_id = trk_id[t];
                r.track_x = trk_x[t];
                r.track_y = trk_y[t];
                r.seen_now = (trk_unseen[t] == 8'd0);
                r.no_tracks = 1'b0;
                r.overflowed = ovf_pending;
                r.last_of_frame = (t + 1 == trk_n);
                expect_item(r);
            end
        det_n = 0;
        ovf_pending = 1'b0;
    endtask

    always @(posedge clk)
    begin
        took = rst_n && start && !busy;
        if (took)
            absorb_point(point);
        if (rst_n && strobe)
        begin
            results_seen++;
            if (expected_tracks.size() == 0)
            begin
                $display("%0t: unexpected item %h", $time, track);
                errors++;
            end
            else
            begin
                track_item_t e;
                e = expected_tracks.pop_front();
                if (e !== track)
                begin
                    $display("%0t: mismatch expected id=%h x=%h y=%h s=%b n=%b o=%b l=%b",
                             $time, e.track_id, e.track_x, e.track_y, e.seen_now,
                             e.no_tracks, e.overflowed, e.last_of_frame);
                    $display("%0t:          actual   id=%h x=%h y=%h s=%b n=%b o=%b l=%b",
                             $time, track.track_id, track.track_x, track.track_y,
                             track.seen_now, track.no_tracks, track.overflowed,
                             track.last_of_frame);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(point_item_t p, bit hold_on);
        int gap;
        gap = hold_on ? 0 : gap_len();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        point = p;
        start = 1'b1;
        do
            @(negedge clk);
        while (!took);
    endtask

    task automatic idle_wait();
        start = 1'b0;
        while (expected_tracks.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            RegMatchDistance: cfg_match = val[22:0];
            RegSmoothingGain: cfg_gain = val[8:0];
            RegStaleLimit:    cfg_stale = val[7:0];
            default: ;
        endcase
    endtask

    function automatic point_item_t mk(int x, int y, bit hp, bit fe);
        point_item_t p;
        p.point_x = 24'(x);
        p.point_y = 24'(y);
        p.has_point = hp;
        p.frame_end = fe;
        return p;
    endfunction

    function automatic logic signed [23:0] near_coord(logic signed [23:0] c);
        return c + 24'($signed($urandom_range(0, 1023)) - 512);
    endfunction

    task automatic random_frames(int unsigned items);
        int unsigned sent;
        int          n;
        point_item_t p;
        bit          hold;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(14, 20);
                1, 2:    n = 0;
                default: n = $urandom_range(1, 5);
            endcase
            hold = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(mk($urandom, $urandom, 1'b0, 1'b0), hold);
                if (trk_n > 0 && $urandom_range(0, 3) != 0)
                begin
                    int t;
                    t = $urandom_range(0, trk_n - 1);
                    p = mk(near_coord(trk_x[t]), near_coord(trk_y[t]), 1'b1, 1'b0);
                end
                else if ($urandom_range(0, 1) == 0)
                    p = mk($urandom, $urandom, 1'b1, 1'b0);
                else
                    p = mk($signed($urandom_range(0, 8191)) - 4096,
                           $signed($urandom_range(0, 8191)) - 4096, 1'b1, 1'b0);
                p.frame_end = (k == n - 1) && ($urandom_range(0, 2) != 0);
                send_item(p, hold);
                sent++;
                if (p.frame_end)
                    break;
            end
            if (n == 0 || !p.frame_end)
            begin
                p = mk($urandom, $urandom, 1'b0, 1'b1);
                send_item(p, hold);
                sent++;
            end
        end
    endtask

    typedef struct {
        point_item_t item;
        bit          typed;
        track_item_t want;
    } stim_row_t;

    stim_row_t rows [$];

    task automatic add_row(point_item_t item, bit typed, track_item_t want);
        stim_row_t row;
        row.item = item;
        row.typed = typed;
        row.want = want;
        rows.insert(rows.size(), row);
    endtask

    initial
    begin
        track_item_t none_r;
        cycles = 0;
        errors = 0;
        frames_done = 0;
        results_seen = 0;
        took = 1'b0;
        override_row = 1'b0;
        override_item = '0;
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_match = MatchDistanceRst;
        cfg_gain = SmoothingGainRst;
        cfg_stale = StaleLimitRst;
        det_n = 0;
        trk_n = 0;
        ident_next = 16'd0;
        ovf_pending = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        none_r = '0;
        none_r.no_tracks = 1'b1;
        none_r.last_of_frame = 1'b1;
        // empty frame straight after reset
        add_row(mk(0, 0, 1'b0, 1'b1), 1'b1, none_r);
        // extremes open tracks 0 and 1
        add_row(mk(8388607, 8388607, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk(-8388608, -8388608, 1'b1, 1'b1), 1'b0, '0);
        // both matched, near the corners
        add_row(mk(8388607 - 100, 8388607, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk(-8388608, -8388608 + 200, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk(0, 0, 1'b0, 1'b1), 1'b0, '0);
        // equal distances from a fresh track at origin
        add_row(mk(0, 0, 1'b1, 1'b1), 1'b0, '0);
        add_row(mk(10, 0, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk(-10, 0, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk(0, 10, 1'b1, 1'b1), 1'b0, '0);
        // just inside and just outside the radius
        add_row(mk(255, 0, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk(0, -300, 1'b1, 1'b1), 1'b0, '0);
        // ignored item, then empty frame end
        add_row(mk(-1, -1, 1'b0, 1'b0), 1'b0, '0);
        add_row(mk(0, 0, 1'b0, 1'b1), 1'b0, '0);

        foreach (rows[k])
        begin
            override_row = rows[k].typed;
            override_item = rows[k].want;
            send_item(rows[k].item, 1'b0);
            override_row = 1'b0;
        end
        idle_wait();

        random_frames(20);
        idle_wait();
        // no match ever, fast drop
        reg_write(RegMatchDistance, 32'd0);
        reg_write(RegStaleLimit, 32'd0);
        reg_write(RegSmoothingGain, 32'd0);
        random_frames(15);
        idle_wait();
        // widest radius, gain above full scale, tracks never dropped
        reg_write(RegMatchDistance, 32'h007F_FFFF);
        reg_write(RegSmoothingGain, 32'h1FF);
        reg_write(RegStaleLimit, 32'd255);
        random_frames(20);
        idle_wait();
        reg_write(RegMatchDistance, 32'd2000);
        reg_write(RegSmoothingGain, 32'd256);
        reg_write(RegStaleLimit, 32'd254);
        random_frames(15);
        idle_wait();
        reg_write(RegMatchDistance, $urandom_range(100, 5000));
        reg_write(RegSmoothingGain, $urandom_range(1, 255));
        reg_write(RegStaleLimit, $urandom_range(1, 5));
        random_frames(15);
        idle_wait();

        if (expected_tracks.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time,
                     expected_tracks.size());
            errors++;
        end
        $display("covered %0d frames, %0d track items checked, five register settings",
                 frames_done, results_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
